FILE: hdl/lrf_pkg.sv
// Shared types, constants and the CRC byte update for the log record framer.
`timescale 1ns / 1ps

package lrf_pkg;

    localparam int unsigned PosW = 5;

    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] HDR_EXTRA  = 32'd13;
    localparam logic [31:0] COUNT_SAT  = 32'hFFFF_FFFF;

    // Byte positions within the bytes one item can produce.
    localparam logic [PosW-1:0] POS_FLEN  = 5'd0;
    localparam logic [PosW-1:0] POS_TYPE  = 5'd4;
    localparam logic [PosW-1:0] POS_TXID  = 5'd5;
    localparam logic [PosW-1:0] POS_PLEN  = 5'd13;
    localparam logic [PosW-1:0] POS_HLAST = 5'd16;
    localparam logic [PosW-1:0] POS_DATA  = 5'd17;
    localparam logic [PosW-1:0] POS_CRC   = 5'd18;
    localparam logic [PosW-1:0] POS_END   = 5'd21;

    typedef struct packed {
        logic [7:0]  record_type;
        logic [63:0] transaction_id;
        logic [31:0] payload_length;
        logic [31:0] frame_length;
        logic [7:0]  data_byte;
        logic        carries_byte;
        logic        first_of_record;
        logic        last_of_record;
    } t_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        frame_end;
        logic [63:0] sequence_number;
        logic        length_error;
    } t_result;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: hdl/lrf_fifo.sv
// Small first-in first-out queue in flip-flops with full and empty flags.
`timescale 1ns / 1ps

module lrf_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PTR_LAST = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CNT_FULL = CntW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: hdl/lrf_front.sv
// Front end: takes input items, works out the frame length and queues them.
`timescale 1ns / 1ps

module lrf_front #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [7:0]           i_record_type,
    input  logic [63:0]          i_transaction_id,
    input  logic [31:0]          i_payload_length,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_carries_byte,
    input  logic                 i_first_of_record,
    input  logic                 i_last_of_record,
    input  logic                 i_take,
    output lrf_pkg::t_item       o_item,
    output logic                 o_item_valid
);

    lrf_pkg::t_item in_item;
    logic [$bits(lrf_pkg::t_item)-1:0] head_bits;
    logic          q_empty;

    always_comb begin
        in_item.record_type     = i_record_type;
        in_item.transaction_id  = i_transaction_id;
        in_item.payload_length  = i_payload_length;
        in_item.frame_length    = i_payload_length + lrf_pkg::HDR_EXTRA;
        in_item.data_byte       = i_data_byte;
        in_item.carries_byte    = i_carries_byte;
        in_item.first_of_record = i_first_of_record;
        in_item.last_of_record  = i_last_of_record;
    end

    lrf_fifo #(
        .WIDTH ($bits(lrf_pkg::t_item)),
        .DEPTH (DEPTH)
    ) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (in_item),
        .o_full  (o_full),
        .i_pop   (i_take),
        .o_data  (head_bits),
        .o_empty (q_empty)
    );

    assign o_item       = lrf_pkg::t_item'(head_bits);
    assign o_item_valid = !q_empty;

endmodule

FILE: hdl/lrf_back.sv
// Back end: walks through the bytes of each queued item, keeps the CRC and record state.
`timescale 1ns / 1ps

module lrf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lrf_pkg::t_item       i_item,
    input  logic                 i_item_valid,
    output logic                 o_take,
    input  logic                 i_cfg_write,
    input  logic [63:0]          i_cfg_first_sequence,
    output lrf_pkg::t_result     o_result,
    output logic                 o_result_push,
    input  logic                 i_result_full
);

    logic                      r_busy;
    logic [lrf_pkg::PosW-1:0]  r_pos;
    logic [31:0]               r_crc;
    logic [63:0]               r_next_seq;
    logic [31:0]               r_bytes_seen;
    logic [31:0]               r_declared;

    logic                      has_work;
    logic [lrf_pkg::PosW-1:0]  start_pos;
    logic [lrf_pkg::PosW-1:0]  cur_pos;
    logic [lrf_pkg::PosW-1:0]  n_pos;
    logic [lrf_pkg::PosW-1:0]  txid_off;
    logic [lrf_pkg::PosW-1:0]  plen_off;
    logic [lrf_pkg::PosW-1:0]  crc_off;
    logic [31:0]               crc_out;
    logic [7:0]                cur_byte;
    logic                      step_done;
    logic                      emit;
    logic                      advance;

    assign has_work = i_item.first_of_record || i_item.carries_byte || i_item.last_of_record;

    always_comb begin
        priority if (i_item.first_of_record) begin
            start_pos = lrf_pkg::POS_FLEN;
        end else if (i_item.carries_byte) begin
            start_pos = lrf_pkg::POS_DATA;
        end else begin
            start_pos = lrf_pkg::POS_CRC;
        end
    end

    assign cur_pos  = r_busy ? r_pos : start_pos;
    assign emit     = i_item_valid && (r_busy || has_work);
    assign advance  = emit && !i_result_full;
    assign txid_off = cur_pos - lrf_pkg::POS_TXID;
    assign plen_off = cur_pos - lrf_pkg::POS_PLEN;
    assign crc_off  = cur_pos - lrf_pkg::POS_CRC;
    assign crc_out  = ~r_crc;

    always_comb begin
        step_done = 1'b0;
        n_pos     = cur_pos + 1'b1;
        priority if (cur_pos < lrf_pkg::POS_HLAST) begin
            step_done = 1'b0;
        end else if (cur_pos == lrf_pkg::POS_HLAST) begin
            if (i_item.carries_byte) begin
                n_pos = lrf_pkg::POS_DATA;
            end else if (i_item.last_of_record) begin
                n_pos = lrf_pkg::POS_CRC;
            end else begin
                step_done = 1'b1;
            end
        end else if (cur_pos == lrf_pkg::POS_DATA) begin
            if (i_item.last_of_record) begin
                n_pos = lrf_pkg::POS_CRC;
            end else begin
                step_done = 1'b1;
            end
        end else if (cur_pos < lrf_pkg::POS_END) begin
            step_done = 1'b0;
        end else begin
            step_done = 1'b1;
        end
    end

    always_comb begin
        priority if (cur_pos < lrf_pkg::POS_TYPE) begin
            cur_byte = 8'(i_item.frame_length >> {cur_pos[1:0], 3'b000});
        end else if (cur_pos == lrf_pkg::POS_TYPE) begin
            cur_byte = i_item.record_type;
        end else if (cur_pos < lrf_pkg::POS_PLEN) begin
            cur_byte = 8'(i_item.transaction_id >> {txid_off[2:0], 3'b000});
        end else if (cur_pos < lrf_pkg::POS_DATA) begin
            cur_byte = 8'(i_item.payload_length >> {plen_off[1:0], 3'b000});
        end else if (cur_pos == lrf_pkg::POS_DATA) begin
            cur_byte = i_item.data_byte;
        end else begin
            cur_byte = 8'(crc_out >> {crc_off[1:0], 3'b000});
        end
    end

    always_comb begin
        o_result.out_byte        = cur_byte;
        o_result.frame_end       = (cur_pos == lrf_pkg::POS_END);
        o_result.sequence_number = (cur_pos == lrf_pkg::POS_END) ? r_next_seq : 64'd0;
        o_result.length_error    = (cur_pos == lrf_pkg::POS_END) && (r_bytes_seen != r_declared);
    end

    assign o_result_push = advance;
    assign o_take = i_item_valid && ((!r_busy && !has_work) || (advance && step_done));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_pos        <= lrf_pkg::POS_FLEN;
            r_crc        <= lrf_pkg::CRC_INIT;
            r_next_seq   <= 64'd1;
            r_bytes_seen <= '0;
            r_declared   <= '0;
        end else begin
            if (i_cfg_write) begin
                r_next_seq <= i_cfg_first_sequence;
            end else if (advance && cur_pos == lrf_pkg::POS_END) begin
                r_next_seq <= r_next_seq + 64'd1;
            end
            if (advance) begin
                r_busy <= !step_done;
                r_pos  <= n_pos;
                if (cur_pos == lrf_pkg::POS_FLEN) begin
                    r_crc        <= lrf_pkg::CRC_INIT;
                    r_bytes_seen <= '0;
                    r_declared   <= i_item.payload_length;
                end else if (cur_pos >= lrf_pkg::POS_TYPE && cur_pos <= lrf_pkg::POS_DATA) begin
                    r_crc <= lrf_pkg::crc_byte(r_crc, cur_byte);
                end else if (cur_pos == lrf_pkg::POS_END) begin
                    r_crc        <= lrf_pkg::CRC_INIT;
                    r_bytes_seen <= '0;
                    r_declared   <= '0;
                end
                if (cur_pos == lrf_pkg::POS_DATA && r_bytes_seen != lrf_pkg::COUNT_SAT) begin
                    r_bytes_seen <= r_bytes_seen + 32'd1;
                end
            end
        end
    end

endmodule

FILE: hdl/log_record_framer_crc32.sv
// Top level of the log record framer: input queue, byte sequencer and result queue.
`timescale 1ns / 1ps

// Each item is turned into the bytes of a length-prefixed frame with a trailing
// CRC-32. A single byte sequencer produces one frame byte per clock cycle while the
// result queue is not full: 17 header bytes for an item that opens a record, one
// for a payload byte and 4 CRC bytes for an item that closes a record, between 1
// and 22 bytes per item in all. Payload-only items therefore stream at one item per
// cycle while the result queue has room. Items with nothing to emit are dropped
// without producing a byte. Queues of QUEUE_DEPTH entries on both sides let input
// and output stall independently. A write of the first sequence number also loads
// the next one.
module log_record_framer_crc32 #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_record_type,
    input  logic [63:0] i_transaction_id,
    input  logic [31:0] i_payload_length,
    input  logic [7:0]  i_data_byte,
    input  logic        i_carries_byte,
    input  logic        i_first_of_record,
    input  logic        i_last_of_record,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_cfg_first_sequence,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_end,
    output logic [63:0] o_sequence_number,
    output logic        o_length_error
);

    lrf_pkg::t_item   head_item;
    logic             head_valid;
    logic             take;
    lrf_pkg::t_result result;
    logic             result_push;
    logic             result_full;
    logic [$bits(lrf_pkg::t_result)-1:0] out_bits;
    lrf_pkg::t_result out_result;

    assign o_cfg_ready = 1'b1;

    lrf_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .o_full            (full),
        .i_record_type     (i_record_type),
        .i_transaction_id  (i_transaction_id),
        .i_payload_length  (i_payload_length),
        .i_data_byte       (i_data_byte),
        .i_carries_byte    (i_carries_byte),
        .i_first_of_record (i_first_of_record),
        .i_last_of_record  (i_last_of_record),
        .i_take            (take),
        .o_item            (head_item),
        .o_item_valid      (head_valid)
    );

    lrf_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_item               (head_item),
        .i_item_valid         (head_valid),
        .o_take               (take),
        .i_cfg_write          (i_cfg_valid && o_cfg_ready),
        .i_cfg_first_sequence (i_cfg_first_sequence),
        .o_result             (result),
        .o_result_push        (result_push),
        .i_result_full        (result_full)
    );

    lrf_fifo #(
        .WIDTH ($bits(lrf_pkg::t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (result_push),
        .i_data  (result),
        .o_full  (result_full),
        .i_pop   (pop),
        .o_data  (out_bits),
        .o_empty (empty)
    );

    assign out_result        = lrf_pkg::t_result'(out_bits);
    assign o_out_byte        = out_result.out_byte;
    assign o_frame_end       = out_result.frame_end;
    assign o_sequence_number = out_result.sequence_number;
    assign o_length_error    = out_result.length_error;

endmodule

FILE: hdl/lrf_checker.sv
// Port-level checks for the log record framer and their binding to the top level.
`timescale 1ns / 1ps

module lrf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  o_out_byte,
    input logic        o_frame_end,
    input logic [63:0] o_sequence_number,
    input logic        o_length_error
);

    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    a_fields_only_at_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_frame_end) |-> (o_sequence_number == 64'd0 && !o_length_error))
        else $error("sequence number or length flag outside frame end");

    a_end_not_twice : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_frame_end) |=> !(!empty && o_frame_end))
        else $error("two frame ends with no CRC bytes between them");

    a_stall_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_frame_end)))
        else $error("waiting result changed before its transfer");

endmodule

bind log_record_framer_crc32 lrf_checker u_lrf_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .full              (full),
    .empty             (empty),
    .pop               (pop),
    .o_out_byte        (o_out_byte),
    .o_frame_end       (o_frame_end),
    .o_sequence_number (o_sequence_number),
    .o_length_error    (o_length_error)
);
